// ===== rtl/tvsg_pkg.sv =====
// Shared types, constants and helpers for the text video scan generator.
`default_nettype none
package tvsg_pkg;

  localparam int COLUMNS_DEF       = 80;
  localparam int TEXT_ROWS_DEF     = 16;
  localparam int SCANS_PER_ROW_DEF = 10;
  localparam int VIDEO_BYTES_DEF   = 1280;

  localparam int GLYPH_BYTES = 512;
  localparam int GLYPH_AW    = 9;
  localparam int ROW_STRIDE  = 16;

  localparam int OP_W   = 2;
  localparam int ADDR_W = 11;
  localparam int DATA_W = 8;
  localparam int COL_W  = 7;
  localparam int CELL_W = 4;
  localparam int ROW_W  = 4;
  localparam int LINE_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_VIDEO_WR = 2'd0,
    OP_GLYPH_WR = 2'd1,
    OP_SCAN     = 2'd2
  } op_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [CELL_W-1:0] cell_row;
    logic [LINE_W-1:0] scan_line;
    logic              last;
    logic              blank;
  } pos_t;

  // g5..g0 = v2 v1 v0 v3 v4 v5
  function automatic logic [5:0] glyph_number(input logic [5:0] v);
    glyph_number = {v[2], v[1], v[0], v[3], v[4], v[5]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tvsg_raster.sv =====
// Raster position counters and running video address.
`default_nettype none
module tvsg_raster
  import tvsg_pkg::*;
#(
  parameter int COLUMNS       = COLUMNS_DEF,
  parameter int TEXT_ROWS     = TEXT_ROWS_DEF,
  parameter int SCANS_PER_ROW = SCANS_PER_ROW_DEF,
  parameter int VIDEO_BYTES   = VIDEO_BYTES_DEF,
  localparam int VA_W         = $clog2(VIDEO_BYTES)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            advance,
  output pos_t                 pos,
  output logic [VA_W-1:0]      vaddr
);

  logic [COL_W-1:0]  column_r, column_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [VA_W-1:0]   vaddr_r, vaddr_nxt;
  logic [VA_W:0]     vsum;
  logic              col_last, cell_last, row_last;

  always_comb begin
    col_last  = column_r == COL_W'(COLUMNS - 1);
    cell_last = cell_r == CELL_W'(SCANS_PER_ROW - 1);
    row_last  = row_r == ROW_W'(TEXT_ROWS - 1);

    pos.column    = column_r;
    pos.cell_row  = cell_r;
    pos.scan_line = LINE_W'(({4'b0, row_r} * LINE_W'(SCANS_PER_ROW)) + {4'b0, cell_r});
    pos.last      = col_last && cell_last && row_last;
    pos.blank     = (cell_r == '0) || cell_last;
    vaddr         = vaddr_r;

    vsum = {1'b0, vaddr_r} + (VA_W+1)'(ROW_STRIDE);
    if (vsum >= (VA_W+1)'(VIDEO_BYTES)) begin
      vsum = vsum - (VA_W+1)'(VIDEO_BYTES);
    end

    column_nxt = column_r;
    cell_nxt   = cell_r;
    row_nxt    = row_r;
    vaddr_nxt  = vaddr_r;
    if (advance) begin
      if (col_last) begin
        column_nxt = '0;
        if (cell_last) begin
          cell_nxt = '0;
          row_nxt  = row_last ? '0 : row_r + 1'b1;
        end else begin
          cell_nxt = cell_r + 1'b1;
        end
        vaddr_nxt = VA_W'(row_nxt);
      end else begin
        column_nxt = column_r + 1'b1;
        vaddr_nxt  = vsum[VA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      cell_r   <= '0;
      row_r    <= '0;
      vaddr_r  <= '0;
    end else begin
      column_r <= column_nxt;
      cell_r   <= cell_nxt;
      row_r    <= row_nxt;
      vaddr_r  <= vaddr_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/text_video_scan_generator.sv =====
// Top level of the text video scan generator.
// Each scan request yields one character cell of 8 pixels (bit 7 leftmost) and the
// raster advances by one cell; video and glyph write requests load the stores and
// give no result. A request is taken every cycle unless in_stall is high; a scan
// result is formed by the registered video read followed by the registered glyph
// read. Both stores must be written before they are scanned. When the result
// side stalls, the whole pipeline holds and the input stalls once a scan waits.
`default_nettype none
module text_video_scan_generator
  import tvsg_pkg::*;
#(
  parameter int COLUMNS       = COLUMNS_DEF,
  parameter int TEXT_ROWS     = TEXT_ROWS_DEF,
  parameter int SCANS_PER_ROW = SCANS_PER_ROW_DEF,
  parameter int VIDEO_BYTES   = VIDEO_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [ADDR_W-1:0] in_address,
  input  wire logic [DATA_W-1:0] in_write_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [DATA_W-1:0]      out_pixels,
  output logic [COL_W-1:0]       out_column,
  output logic [LINE_W-1:0]      out_scan_line,
  output logic                   out_last_of_frame
);

  localparam int VA_W = $clog2(VIDEO_BYTES);

  logic [DATA_W-1:0] video_mem [VIDEO_BYTES];
  logic [DATA_W-1:0] glyph_mem [GLYPH_BYTES];

  pos_t              pos, s1_pos_r, out_pos_r;
  logic [VA_W-1:0]   vaddr;
  logic              s1_valid_r, out_valid_r;
  logic [DATA_W-1:0] s1_vdata_r, glyph_r;
  logic              accept, scan_acc, adv1;
  logic [CELL_W-1:0] cell_m1;
  logic [GLYPH_AW-1:0] gaddr;

  assign adv1     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv1;
  assign accept   = in_valid && !in_stall;
  assign scan_acc = accept && (in_op == OP_SCAN);

  assign cell_m1 = s1_pos_r.cell_row - 1'b1;
  assign gaddr   = {glyph_number(s1_vdata_r[5:0]), cell_m1[2:0]};

  tvsg_raster #(
    .COLUMNS       (COLUMNS),
    .TEXT_ROWS     (TEXT_ROWS),
    .SCANS_PER_ROW (SCANS_PER_ROW),
    .VIDEO_BYTES   (VIDEO_BYTES)
  ) u_raster (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (scan_acc),
    .pos     (pos),
    .vaddr   (vaddr)
  );

  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_VIDEO_WR) &&
        ({1'b0, in_address} < (ADDR_W+1)'(VIDEO_BYTES))) begin
      video_mem[in_address[VA_W-1:0]] <= in_write_data;
    end
    if (scan_acc) begin
      s1_vdata_r <= video_mem[vaddr];
      s1_pos_r   <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_GLYPH_WR)) begin
      glyph_mem[in_address[GLYPH_AW-1:0]] <= in_write_data;
    end
    if (adv1) begin
      glyph_r   <= glyph_mem[gaddr];
      out_pos_r <= s1_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (scan_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv1) begin
        s1_valid_r <= 1'b0;
      end
      if (adv1) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixels        = out_pos_r.blank ? '0 : glyph_r;
  assign out_column        = out_pos_r.column;
  assign out_scan_line     = out_pos_r.scan_line;
  assign out_last_of_frame = out_pos_r.last;

endmodule
`default_nettype wire

// ===== test/text_video_scan_generator_tb.sv =====
// Testbench for text_video_scan_generator: a directed table, then random requests checked
// against a predictor.
`timescale 1ns / 1ps
module text_video_scan_generator_tb
  import tvsg_pkg::*;
();

  localparam int COLS        = COLUMNS_DEF;
  localparam int TROWS       = TEXT_ROWS_DEF;
  localparam int SCANS       = SCANS_PER_ROW_DEF;
  localparam int VBYTES      = VIDEO_BYTES_DEF;
  localparam int CYCLE_LIMIT = 20000;
  localparam int MIN_REQS    = 1000;
  localparam int DRAIN       = 8;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] pixels;
    logic [COL_W-1:0]  column;
    logic [LINE_W-1:0] scan_line;
    logic              last;
  } cell_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              typed;
    cell_t             want;
  } row_t;

  localparam int NROWS = 15;
  localparam row_t DIRECTED [NROWS] = '{
    '{OP_SCAN,     11'd0,    8'h00, 1'b1, '{8'd0, 7'd0, 8'd0, 1'b0}},
    '{OP_VIDEO_WR, 11'd0,    8'hff, 1'b0, '0},
    '{OP_VIDEO_WR, 11'd1279, 8'h00, 1'b0, '0},
    '{OP_VIDEO_WR, 11'd2047, 8'h55, 1'b0, '0},
    '{OP_VIDEO_WR, 11'd1280, 8'haa, 1'b0, '0},
    '{OP_GLYPH_WR, 11'd2047, 8'hff, 1'b0, '0},
    '{OP_GLYPH_WR, 11'd0,    8'h00, 1'b0, '0},
    '{OP_NONE,     11'd2047, 8'hff, 1'b0, '0},
    '{OP_SCAN,     11'd2047, 8'hff, 1'b1, '{8'd0, 7'd1, 8'd0, 1'b0}},
    '{OP_SCAN,     11'd0,    8'h00, 1'b1, '{8'd0, 7'd2, 8'd0, 1'b0}},
    '{OP_GLYPH_WR, 11'd1536, 8'h81, 1'b0, '0},
    '{OP_VIDEO_WR, 11'd1024, 8'h3f, 1'b0, '0},
    '{OP_SCAN,     11'd0,    8'h00, 1'b1, '{8'd0, 7'd3, 8'd0, 1'b0}},
    '{OP_NONE,     11'd0,    8'h00, 1'b0, '0},
    '{OP_SCAN,     11'd0,    8'h00, 1'b1, '{8'd0, 7'd4, 8'd0, 1'b0}}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_op;
  logic [ADDR_W-1:0] in_address;
  logic [DATA_W-1:0] in_write_data;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] out_pixels;
  logic [COL_W-1:0]  out_column;
  logic [LINE_W-1:0] out_scan_line;
  logic              out_last_of_frame;

  // raster predictor state
  logic [COL_W-1:0]  col_ctr;
  logic [CELL_W-1:0] cell_ctr;
  logic [ROW_W-1:0]  row_ctr;
  logic [DATA_W-1:0] video_mem [VBYTES];
  logic [DATA_W-1:0] glyph_mem [GLYPH_BYTES];
  bit                video_seen [VBYTES];
  bit                glyph_seen [GLYPH_BYTES];

  cell_t pending_cells [$];
  int    errors = 0;
  int    reqs_sent;
  int    cycles = 0;
  bit    steady;

  text_video_scan_generator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixels       (out_pixels),
    .out_column       (out_column),
    .out_scan_line    (out_scan_line),
    .out_last_of_frame(out_last_of_frame)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("text_video_scan_generator test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic bit is_blank();
    return cell_ctr == 0 || cell_ctr >= SCANS - 1;
  endfunction

  function automatic int video_index();
    return (int'(row_ctr) + int'(col_ctr) * ROW_STRIDE) % VBYTES;
  endfunction

  // video bits 2,1,0,3,4,5 form glyph bits 5..0; cell row selects the glyph line
  function automatic logic [GLYPH_AW-1:0] glyph_index(input logic [DATA_W-1:0] v);
    logic [2:0] line;
    line = 3'(cell_ctr - 1);
    return {v[2], v[1], v[0], v[3], v[4], v[5], line};
  endfunction

  task automatic raster_step(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, output bit made,
                             output cell_t c);
    made = 1'b0;
    c = '0;
    case (op)
      OP_VIDEO_WR: begin
        if (addr < VBYTES) begin
          video_mem[addr] = data;
          video_seen[addr] = 1'b1;
        end
      end
      OP_GLYPH_WR: begin
        glyph_mem[addr[GLYPH_AW-1:0]] = data;
        glyph_seen[addr[GLYPH_AW-1:0]] = 1'b1;
      end
      OP_SCAN: begin
        made = 1'b1;
        c.pixels = is_blank() ? '0 : glyph_mem[glyph_index(video_mem[video_index()])];
        c.column = col_ctr;
        c.scan_line = LINE_W'(int'(row_ctr) * SCANS + int'(cell_ctr));
        c.last = col_ctr == COLS - 1 && cell_ctr == SCANS - 1 && row_ctr == TROWS - 1;
        if (col_ctr + 1 >= COLS) begin
          col_ctr = '0;
          if (cell_ctr + 1 >= SCANS) begin
            cell_ctr = '0;
            row_ctr = (row_ctr + 1 >= TROWS) ? '0 : row_ctr + 1'b1;
          end else begin
            cell_ctr = cell_ctr + 1'b1;
          end
        end else begin
          col_ctr = col_ctr + 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data, input bit use_given = 1'b0,
                              input cell_t given = '0);
    bit    made;
    cell_t c;
    while (!steady && $urandom_range(99) < 24) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_op         <= op;
    in_address    <= addr;
    in_write_data <= data;
    do @(posedge clk); while (in_stall);
    raster_step(op, addr, data, made, c);
    if (made) pending_cells.push_back(use_given ? given : c);
    if (op != OP_NONE) reqs_sent++;
    steady = reqs_sent >= 400 && reqs_sent < 600;
  endtask

  // make sure the entries a scan will read were loaded first
  task automatic scan_cell();
    int                 vi;
    logic [GLYPH_AW-1:0] gi;
    if (!is_blank()) begin
      vi = video_index();
      if (!video_seen[vi]) send_request(OP_VIDEO_WR, ADDR_W'(vi), 8'($urandom));
      gi = glyph_index(video_mem[vi]);
      if (!glyph_seen[gi])
        send_request(OP_GLYPH_WR, {2'($urandom), gi}, 8'($urandom));
    end
    send_request(OP_SCAN, 11'($urandom), 8'($urandom));
  endtask

  always @(negedge clk) begin
    out_stall <= !steady && $urandom_range(99) < 24;
  end

  always @(posedge clk) begin : check_cells
    cell_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cells.size() == 0) begin
        report_mismatch("unexpected cell at column", int'(out_column), 0);
      end else begin
        want = pending_cells.pop_front();
        if (out_pixels !== want.pixels)
          report_mismatch("pixels", int'(out_pixels), int'(want.pixels));
        if (out_column !== want.column)
          report_mismatch("column", int'(out_column), int'(want.column));
        if (out_scan_line !== want.scan_line)
          report_mismatch("scan_line", int'(out_scan_line), int'(want.scan_line));
        if (out_last_of_frame !== want.last)
          report_mismatch("last_of_frame", int'(out_last_of_frame), int'(want.last));
      end
    end
  end

  initial begin
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_VIDEO_WR;
    in_address = '0;
    in_write_data = '0;
    col_ctr = '0;
    cell_ctr = '0;
    row_ctr = '0;
    reqs_sent = 0;
    steady = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NROWS; i++)
      send_request(DIRECTED[i].op, DIRECTED[i].addr, DIRECTED[i].data, DIRECTED[i].typed,
                   DIRECTED[i].want);

    while (reqs_sent < MIN_REQS) begin
      r = $urandom_range(99);
      if (r < 80) scan_cell();
      else if (r < 88) send_request(OP_VIDEO_WR, 11'($urandom), 8'($urandom));
      else if (r < 96) send_request(OP_GLYPH_WR, 11'($urandom), 8'($urandom));
      else send_request(OP_NONE, 11'($urandom), 8'($urandom));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("text_video_scan_generator test passed");
    end else begin
      $display("text_video_scan_generator test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tvsg_pkg.sv
rtl/tvsg_raster.sv
rtl/text_video_scan_generator.sv
test/text_video_scan_generator_tb.sv
